[design/hciupd_pkg.sv]
// Shared types and constants for the serial HCI packet deframer.
package hciupd_pkg;

  localparam logic [7:0]  TYPE_EVENT = 8'h04;
  localparam logic [7:0]  TYPE_DATA  = 8'h02;

  localparam logic [16:0] EVT_LAST_HDR_OFF  = 17'd1;
  localparam logic [16:0] DATA_LAST_HDR_OFF = 17'd3;
  localparam logic [16:0] DATA_LEN_LO_OFF   = 17'd2;
  localparam logic [15:0] EVT_HDR_LEN  = 16'd2;
  localparam logic [15:0] DATA_HDR_LEN = 16'd4;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_t;

endpackage

[design/hci_uart_packet_deframer.sv]
// Top level: byte stream to HCI packet deframer with length guard.
//
// channel | dir | tdata                                  | tuser                      | tlast
// in_     | in  | [7:0] rx_byte                          | -                          | -
// out_    | out | [7:0] data_byte, [24:8] byte_offset    | [0] packet_kind, [2:1] st  | last
// cfg_    | in  | [15:0] max_payload                     | -                          | -
//
// One beat per cycle while the result register is not stalled: input register,
// one decode step, result register.
// A stalled result register holds the input register, which still takes one beat.
// rst_n is synchronous; max_payload resets to 1024, parser waits for a type byte.
module hci_uart_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [24:8] byte_offset, [31:25] zero
  output logic [2:0]  out_tuser,  // [0] packet_kind, [2:1] status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] max_payload
);
  import hciupd_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE     = 2'd0,
    PH_EVT_HDR  = 2'd1,
    PH_DATA_HDR = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] left_r, left_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] max_payload_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;

  logic        res_vld;
  kind_t       res_kind;
  logic [16:0] res_off;
  logic        res_last;
  status_t     res_status;
  logic [15:0] hdr_len;
  logic        hdr_final;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [16:0] out_off_r;
  kind_t       out_kind_r;
  status_t     out_status_r;
  logic        out_last_r;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    len_lo_nxt = len_lo_r;
    res_vld    = 1'b0;
    res_kind   = kind_r;
    res_off    = pos_r;
    res_last   = 1'b0;
    res_status = ST_OK;
    hdr_final  = 1'b0;
    hdr_len    = {s1_byte_r, len_lo_r};
    unique case (phase_r)
      PH_TYPE: begin
        pos_nxt = '0;
        if (s1_byte_r == TYPE_EVENT) begin
          kind_nxt  = KIND_EVENT;
          phase_nxt = PH_EVT_HDR;
          left_nxt  = EVT_HDR_LEN;
        end else if (s1_byte_r == TYPE_DATA) begin
          kind_nxt  = KIND_DATA;
          phase_nxt = PH_DATA_HDR;
          left_nxt  = DATA_HDR_LEN;
        end else begin
          res_vld    = 1'b1;
          res_kind   = KIND_EVENT;
          res_off    = '0;
          res_last   = 1'b1;
          res_status = ST_BAD_TYPE;
          left_nxt   = '0;
          len_lo_nxt = '0;
        end
      end
      PH_EVT_HDR: begin
        res_vld = 1'b1;
        if (pos_r >= EVT_LAST_HDR_OFF) begin
          hdr_final = 1'b1;
          hdr_len   = {8'd0, s1_byte_r};
        end else begin
          pos_nxt  = pos_r + 17'd1;
          left_nxt = 16'd1;
        end
      end
      PH_DATA_HDR: begin
        res_vld = 1'b1;
        if (pos_r >= DATA_LAST_HDR_OFF) begin
          hdr_final = 1'b1;
        end else begin
          if (pos_r == DATA_LEN_LO_OFF) len_lo_nxt = s1_byte_r;
          pos_nxt  = pos_r + 17'd1;
          left_nxt = DATA_HDR_LEN - pos_r[15:0] - 16'd1;
        end
      end
      PH_PAYLOAD: begin
        res_vld = 1'b1;
        if (left_r <= 16'd1) begin
          res_last   = 1'b1;
          phase_nxt  = PH_TYPE;
          left_nxt   = '0;
          pos_nxt    = '0;
          len_lo_nxt = '0;
        end else begin
          left_nxt = left_r - 16'd1;
          pos_nxt  = pos_r + 17'd1;
        end
      end
      default: ;
    endcase

    // final header byte: length decides between payload, empty and oversize
    if (hdr_final) begin
      if (hdr_len > max_payload_r || hdr_len == 16'd0) begin
        res_last   = 1'b1;
        res_status = (hdr_len > max_payload_r) ? ST_OVERSIZE : ST_OK;
        phase_nxt  = PH_TYPE;
        left_nxt   = '0;
        pos_nxt    = '0;
        len_lo_nxt = '0;
      end else begin
        phase_nxt = PH_PAYLOAD;
        left_nxt  = hdr_len;
        pos_nxt   = pos_r + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TYPE;
      kind_r        <= KIND_EVENT;
      left_r        <= '0;
      pos_r         <= '0;
      len_lo_r      <= '0;
      max_payload_r <= MAX_PAYLOAD_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_payload_r <= cfg_data;
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_adv) begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        left_r   <= left_nxt;
        pos_r    <= pos_nxt;
        len_lo_r <= len_lo_nxt;
      end
      if (s1_adv) out_valid_r <= res_vld;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_byte_r <= in_tdata;
    if (s1_adv && res_vld) begin
      out_byte_r   <= s1_byte_r;
      out_off_r    <= res_off;
      out_kind_r   <= res_kind;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_off_r, out_byte_r};
  assign out_tuser  = {out_status_r, out_kind_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_bad_type_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_BAD_TYPE |-> out_last_r && out_off_r == '0)
    else $error("bad type result not a single last beat");

  a_oversize_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OVERSIZE |-> out_last_r)
    else $error("oversize result not marked last");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 16'd0)
    else $error("payload phase with nothing left");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_off_r))
    else $error("stalled result lost");
`endif

endmodule
